// ----- design/trcuv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trcuv_pkg
// Shared types, constants and the divider step for the scissor clip block.
// ----------------------------------------------------------------------------
package trcuv_pkg;

  localparam int unsigned LANES       = 4;
  localparam int unsigned UV_W        = 17;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned QUO_W       = 33;
  localparam int unsigned DIV_BPS     = 4;
  localparam int unsigned DIV_STAGES  = (QUO_W + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned DIV_W       = DIV_STAGES * DIV_BPS;
  localparam logic [UV_W-1:0] UV_MAX  = {UV_W{1'b1}};

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_CLIP_ENABLE = 3'd0,
    REG_CLIP_LEFT   = 3'd1,
    REG_CLIP_TOP    = 3'd2,
    REG_CLIP_RIGHT  = 3'd3,
    REG_CLIP_BOTTOM = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] rect_left;
    logic signed [PIX_W-1:0] rect_top;
    logic signed [PIX_W-1:0] rect_right;
    logic signed [PIX_W-1:0] rect_bottom;
    logic [UV_W-1:0]         tex_u_start;
    logic [UV_W-1:0]         tex_v_start;
    logic [UV_W-1:0]         tex_u_end;
    logic [UV_W-1:0]         tex_v_end;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] out_left;
    logic signed [PIX_W-1:0] out_top;
    logic signed [PIX_W-1:0] out_right;
    logic signed [PIX_W-1:0] out_bottom;
    logic [UV_W-1:0]         out_u_start;
    logic [UV_W-1:0]         out_v_start;
    logic [UV_W-1:0]         out_u_end;
    logic [UV_W-1:0]         out_v_end;
    logic                    visible;
  } out_item_t;

  typedef struct packed {
    logic                    enable;
    logic signed [PIX_W-1:0] left;
    logic signed [PIX_W-1:0] top;
    logic signed [PIX_W-1:0] right;
    logic signed [PIX_W-1:0] bottom;
  } cfg_t;

  // data that rides alongside the divider lanes
  typedef struct packed {
    logic signed [PIX_W-1:0]      ol;
    logic signed [PIX_W-1:0]      ot;
    logic signed [PIX_W-1:0]      orr;
    logic signed [PIX_W-1:0]      ob;
    logic [LANES-1:0][UV_W-1:0]   base;
    logic [LANES-1:0]             neg;
    logic                         vis;
  } side_t;

  typedef struct packed {
    logic [PIX_W-1:0] rem;
    logic [DIV_W-1:0] word;
  } div_st_t;

  // DIV_BPS restoring steps: shift numerator bits into the remainder,
  // shift quotient bits into the bottom of the word
  function automatic div_st_t div_group(input logic [PIX_W-1:0] rem,
                                        input logic [DIV_W-1:0] word,
                                        input logic [PIX_W-1:0] den);
    logic [PIX_W:0] r;
    logic [DIV_W-1:0] w;
    div_st_t res;
    r = {1'b0, rem};
    w = word;
    for (int i = 0; i < DIV_BPS; i++) begin
      r = {r[PIX_W-1:0], w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        w[0] = 1'b1;
      end
    end
    res.rem  = r[PIX_W-1:0];
    res.word = w;
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- design/trcuv_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trcuv_front
// Edge clip, spans and cut distances (stage 1), span times cut (stage 2).
// ----------------------------------------------------------------------------
module trcuv_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   en,
  input  wire logic                                   in_vld,
  input  wire trcuv_pkg::in_item_t                    in_item,
  input  wire trcuv_pkg::cfg_t                        cfg,
  output logic                                        out_vld,
  output trcuv_pkg::side_t                            out_side,
  output logic [trcuv_pkg::LANES-1:0][trcuv_pkg::QUO_W-1:0] out_num,
  output logic [trcuv_pkg::LANES-1:0][trcuv_pkg::PIX_W-1:0] out_den
);
  import trcuv_pkg::*;

  logic signed [PIX_W:0] d_l, d_t, d_r, d_b, w, h, ow, oh;
  logic signed [UV_W:0]  su, sv;
  logic [UV_W-1:0]       mag_u, mag_v;
  logic                  c_l, c_t, c_r, c_b, w_pos, h_pos;
  side_t                 side_nxt;
  logic [LANES-1:0][UV_W-1:0]  mag_nxt;
  logic [LANES-1:0][PIX_W-1:0] cut_nxt, den_nxt;

  logic                        v1_r, v2_r;
  side_t                       side1_r, side2_r;
  logic [LANES-1:0][UV_W-1:0]  mag1_r;
  logic [LANES-1:0][PIX_W-1:0] cut1_r, den1_r, den2_r;
  logic [LANES-1:0][QUO_W-1:0] num2_r;

  always_comb begin
    d_l = {cfg.left[PIX_W-1], cfg.left} - {in_item.rect_left[PIX_W-1], in_item.rect_left};
    d_t = {cfg.top[PIX_W-1], cfg.top} - {in_item.rect_top[PIX_W-1], in_item.rect_top};
    d_r = {in_item.rect_right[PIX_W-1], in_item.rect_right} - {cfg.right[PIX_W-1], cfg.right};
    d_b = {in_item.rect_bottom[PIX_W-1], in_item.rect_bottom}
          - {cfg.bottom[PIX_W-1], cfg.bottom};
    w   = {in_item.rect_right[PIX_W-1], in_item.rect_right}
          - {in_item.rect_left[PIX_W-1], in_item.rect_left};
    h   = {in_item.rect_bottom[PIX_W-1], in_item.rect_bottom}
          - {in_item.rect_top[PIX_W-1], in_item.rect_top};
    c_l = cfg.enable && (d_l > 0);
    c_t = cfg.enable && (d_t > 0);
    c_r = cfg.enable && (d_r > 0);
    c_b = cfg.enable && (d_b > 0);
    w_pos = w > 0;
    h_pos = h > 0;

    side_nxt.ol  = c_l ? cfg.left   : in_item.rect_left;
    side_nxt.ot  = c_t ? cfg.top    : in_item.rect_top;
    side_nxt.orr = c_r ? cfg.right  : in_item.rect_right;
    side_nxt.ob  = c_b ? cfg.bottom : in_item.rect_bottom;
    ow = {side_nxt.orr[PIX_W-1], side_nxt.orr} - {side_nxt.ol[PIX_W-1], side_nxt.ol};
    oh = {side_nxt.ob[PIX_W-1], side_nxt.ob} - {side_nxt.ot[PIX_W-1], side_nxt.ot};
    side_nxt.vis = !cfg.enable || ((ow > 0) && (oh > 0));

    su = {1'b0, in_item.tex_u_end} - {1'b0, in_item.tex_u_start};
    sv = {1'b0, in_item.tex_v_end} - {1'b0, in_item.tex_v_start};
    mag_u = su[UV_W] ? UV_W'(-su) : su[UV_W-1:0];
    mag_v = sv[UV_W] ? UV_W'(-sv) : sv[UV_W-1:0];

    side_nxt.base = {in_item.tex_v_end, in_item.tex_u_end,
                     in_item.tex_v_start, in_item.tex_u_start};
    // start coordinates subtract the delta when the span is negative, end coordinates when it is positive
    side_nxt.neg  = {!sv[UV_W], !su[UV_W], sv[UV_W], su[UV_W]};
    mag_nxt = {mag_v, mag_u, mag_v, mag_u};
    cut_nxt[0] = (c_l && w_pos) ? d_l[PIX_W-1:0] : '0;
    cut_nxt[1] = (c_t && h_pos) ? d_t[PIX_W-1:0] : '0;
    cut_nxt[2] = (c_r && w_pos) ? d_r[PIX_W-1:0] : '0;
    cut_nxt[3] = (c_b && h_pos) ? d_b[PIX_W-1:0] : '0;
    den_nxt[0] = w_pos ? w[PIX_W-1:0] : PIX_W'(1);
    den_nxt[1] = h_pos ? h[PIX_W-1:0] : PIX_W'(1);
    den_nxt[2] = den_nxt[0];
    den_nxt[3] = den_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_nxt;
      mag1_r  <= mag_nxt;
      cut1_r  <= cut_nxt;
      den1_r  <= den_nxt;
      side2_r <= side1_r;
      den2_r  <= den1_r;
      for (int i = 0; i < LANES; i++) begin
        num2_r[i] <= QUO_W'(mag1_r[i]) * QUO_W'(cut1_r[i]);
      end
    end
  end

  assign out_vld  = v2_r;
  assign out_side = side2_r;
  assign out_num  = num2_r;
  assign out_den  = den2_r;

endmodule
`default_nettype wire

// ----- design/trcuv_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trcuv_div
// Four-lane pipelined restoring divider, DIV_BPS quotient bits per stage.
// ----------------------------------------------------------------------------
module trcuv_div (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   en,
  input  wire logic                                   in_vld,
  input  wire trcuv_pkg::side_t                       in_side,
  input  wire logic [trcuv_pkg::LANES-1:0][trcuv_pkg::QUO_W-1:0] in_num,
  input  wire logic [trcuv_pkg::LANES-1:0][trcuv_pkg::PIX_W-1:0] in_den,
  output logic                                        out_vld,
  output trcuv_pkg::side_t                            out_side,
  output logic [trcuv_pkg::LANES-1:0][trcuv_pkg::QUO_W-1:0] out_quo
);
  import trcuv_pkg::*;

  logic    [DIV_STAGES-1:0]                         vld_r;
  side_t   [DIV_STAGES-1:0]                         side_r;
  logic    [DIV_STAGES-1:0][LANES-1:0][PIX_W-1:0]   rem_r, den_r;
  logic    [DIV_STAGES-1:0][LANES-1:0][DIV_W-1:0]   word_r;
  div_st_t [DIV_STAGES-1:0][LANES-1:0]              step_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      step_nxt[0][i] = div_group('0, DIV_W'(in_num[i]), in_den[i]);
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      for (int i = 0; i < LANES; i++) begin
        step_nxt[s][i] = div_group(rem_r[s-1][i], word_r[s-1][i], den_r[s-1][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int i = 0; i < LANES; i++) begin
        den_r[0][i] <= in_den[i];
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_r[s] <= side_r[s-1];
        for (int i = 0; i < LANES; i++) begin
          den_r[s][i] <= den_r[s-1][i];
        end
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
        for (int i = 0; i < LANES; i++) begin
          rem_r[s][i]  <= step_nxt[s][i].rem;
          word_r[s][i] <= step_nxt[s][i].word;
        end
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_quo[i] = word_r[DIV_STAGES-1][i][QUO_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- design/trcuv_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trcuv_back
// Apply signed deltas, saturate the coordinates, hold the output beat.
// ----------------------------------------------------------------------------
module trcuv_back (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   en,
  input  wire logic                                   in_vld,
  input  wire trcuv_pkg::side_t                       in_side,
  input  wire logic [trcuv_pkg::LANES-1:0][trcuv_pkg::QUO_W-1:0] in_quo,
  output logic                                        out_vld,
  output trcuv_pkg::out_item_t                        out_item
);
  import trcuv_pkg::*;

  logic signed [QUO_W+1:0]     sum;
  logic [LANES-1:0][UV_W-1:0]  uv;
  out_item_t                   item_nxt, item_r;
  logic                        vld_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum = in_side.neg[i]
            ? $signed({{(QUO_W+2-UV_W){1'b0}}, in_side.base[i]}) - $signed({2'b00, in_quo[i]})
            : $signed({{(QUO_W+2-UV_W){1'b0}}, in_side.base[i]}) + $signed({2'b00, in_quo[i]});
      if (sum < 0) begin
        uv[i] = '0;
      end else if (sum > $signed({{(QUO_W+2-UV_W){1'b0}}, UV_MAX})) begin
        uv[i] = UV_MAX;
      end else begin
        uv[i] = sum[UV_W-1:0];
      end
    end
    item_nxt.out_left    = in_side.ol;
    item_nxt.out_top     = in_side.ot;
    item_nxt.out_right   = in_side.orr;
    item_nxt.out_bottom  = in_side.ob;
    item_nxt.out_u_start = uv[0];
    item_nxt.out_v_start = uv[1];
    item_nxt.out_u_end   = uv[2];
    item_nxt.out_v_end   = uv[3];
    item_nxt.visible     = in_side.vis;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule
`default_nettype wire

// ----- design/textured_rect_clip_uv_adjust_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// textured_rect_clip_uv_adjust_top
// Scissor clip of one textured rectangle with matching texture coordinates.
//
// Input beats (in_valid/in_stall/in_data) carry one rectangle with its four
// UVs; each gives one output beat (out_valid/out_stall/out_data) with the
// clipped edges, adjusted UVs and a visible flag. Scissor registers are
// written over cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write
// them only while the pipe is empty.
// Two front stages (clip, multiply), nine divider stages at four quotient
// bits each, one output stage. Throughput is one beat per cycle unless
// out_stall freezes the pipe; the 33-bit divide is fully pipelined.
// Reset empties the pipe, disables clipping and sets the scissor to
// 0..32767 on both axes. While out_stall holds a waiting output beat, the
// whole pipe freezes and in_stall is raised; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module textured_rect_clip_uv_adjust_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire trcuv_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output trcuv_pkg::out_item_t       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);
  import trcuv_pkg::*;

  logic  en;
  cfg_t  cfg_r;
  logic  f_vld, d_vld;
  side_t f_side, d_side;
  logic [LANES-1:0][QUO_W-1:0] f_num, d_quo;
  logic [LANES-1:0][PIX_W-1:0] f_den;

  // advance unless a finished beat is held by the receiver
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b0;
      cfg_r.left   <= '0;
      cfg_r.top    <= '0;
      cfg_r.right  <= 16'sh7FFF;
      cfg_r.bottom <= 16'sh7FFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLIP_ENABLE: cfg_r.enable <= cfg_data[0];
        REG_CLIP_LEFT:   cfg_r.left   <= cfg_data;
        REG_CLIP_TOP:    cfg_r.top    <= cfg_data;
        REG_CLIP_RIGHT:  cfg_r.right  <= cfg_data;
        REG_CLIP_BOTTOM: cfg_r.bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  trcuv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_item  (in_data),
    .cfg      (cfg_r),
    .out_vld  (f_vld),
    .out_side (f_side),
    .out_num  (f_num),
    .out_den  (f_den)
  );

  trcuv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .in_side  (f_side),
    .in_num   (f_num),
    .in_den   (f_den),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_quo  (d_quo)
  );

  trcuv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld),
    .in_side  (d_side),
    .in_quo   (d_quo),
    .out_vld  (out_valid),
    .out_item (out_data)
  );

  a_invis_needs_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.visible |-> cfg_r.enable)
    else $error("invisible result with clipping disabled");

  a_vis_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.visible && cfg_r.enable |->
      out_data.out_left >= cfg_r.left && out_data.out_right <= cfg_r.right &&
      out_data.out_top >= cfg_r.top && out_data.out_bottom <= cfg_r.bottom)
    else $error("visible result outside scissor");

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("output beat right after reset");

endmodule
`default_nettype wire

// ----- tb/textured_rect_clip_uv_adjust_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// textured_rect_clip_uv_adjust_top_test
// Drives rectangles through the scissor clip block under several scissor
// settings, with random gaps on both sides, and checks every output beat
// against a clip-and-interpolate predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module textured_rect_clip_uv_adjust_top_test;
  import trcuv_pkg::*;

  class clip_scoreboard;
    cfg_t      scissor;
    out_item_t pending[$];
    int        errors;

    function new();
      scissor = '{enable: 1'b0, left: 16'sd0, top: 16'sd0,
                  right: 16'sd32767, bottom: 16'sd32767};
      errors  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] val);
      case (idx)
        REG_CLIP_ENABLE: scissor.enable = val[0];
        REG_CLIP_LEFT:   scissor.left   = val;
        REG_CLIP_TOP:    scissor.top    = val;
        REG_CLIP_RIGHT:  scissor.right  = val;
        REG_CLIP_BOTTOM: scissor.bottom = val;
        default: ;
      endcase
    endfunction

    function logic [UV_W-1:0] clamp_uv(longint v);
      if (v < 0) return '0;
      if (v > longint'(UV_MAX)) return UV_MAX;
      return v[UV_W-1:0];
    endfunction

    function longint uv_shift(longint span, longint cut, longint extent);
      if (extent <= 0) return 0;
      return (span * cut) / extent;
    endfunction

    function void note_input(in_item_t it);
      out_item_t o;
      longint w, h, su, sv, l, t, r, b, us, vs, ue, ve;
      l = it.rect_left;  t = it.rect_top;
      r = it.rect_right; b = it.rect_bottom;
      us = it.tex_u_start; vs = it.tex_v_start;
      ue = it.tex_u_end;   ve = it.tex_v_end;
      o.out_left = it.rect_left;   o.out_top = it.rect_top;
      o.out_right = it.rect_right; o.out_bottom = it.rect_bottom;
      o.out_u_start = it.tex_u_start; o.out_v_start = it.tex_v_start;
      o.out_u_end = it.tex_u_end;     o.out_v_end = it.tex_v_end;
      o.visible = 1'b1;
      if (scissor.enable) begin
        w = r - l; h = b - t; su = ue - us; sv = ve - vs;
        if (l < scissor.left) begin
          o.out_left = scissor.left;
          o.out_u_start = clamp_uv(us + uv_shift(su, longint'(scissor.left) - l, w));
        end
        if (t < scissor.top) begin
          o.out_top = scissor.top;
          o.out_v_start = clamp_uv(vs + uv_shift(sv, longint'(scissor.top) - t, h));
        end
        if (r > scissor.right) begin
          o.out_right = scissor.right;
          o.out_u_end = clamp_uv(ue - uv_shift(su, r - longint'(scissor.right), w));
        end
        if (b > scissor.bottom) begin
          o.out_bottom = scissor.bottom;
          o.out_v_end = clamp_uv(ve - uv_shift(sv, b - longint'(scissor.bottom), h));
        end
        if (longint'(o.out_right) - o.out_left <= 0 ||
            longint'(o.out_bottom) - o.out_top <= 0)
          o.visible = 1'b0;
      end
      pending.push_back(o);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("output beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_left !== e.out_left) begin
        $error("out_left exp %0d got %0d", e.out_left, got.out_left); errors++;
      end
      if (got.out_top !== e.out_top) begin
        $error("out_top exp %0d got %0d", e.out_top, got.out_top); errors++;
      end
      if (got.out_right !== e.out_right) begin
        $error("out_right exp %0d got %0d", e.out_right, got.out_right); errors++;
      end
      if (got.out_bottom !== e.out_bottom) begin
        $error("out_bottom exp %0d got %0d", e.out_bottom, got.out_bottom); errors++;
      end
      if (got.out_u_start !== e.out_u_start) begin
        $error("out_u_start exp %0d got %0d", e.out_u_start, got.out_u_start); errors++;
      end
      if (got.out_v_start !== e.out_v_start) begin
        $error("out_v_start exp %0d got %0d", e.out_v_start, got.out_v_start); errors++;
      end
      if (got.out_u_end !== e.out_u_end) begin
        $error("out_u_end exp %0d got %0d", e.out_u_end, got.out_u_end); errors++;
      end
      if (got.out_v_end !== e.out_v_end) begin
        $error("out_v_end exp %0d got %0d", e.out_v_end, got.out_v_end); errors++;
      end
      if (got.visible !== e.visible) begin
        $error("visible exp %0d got %0d", e.visible, got.visible); errors++;
      end
    endfunction
  endclass

  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 5000;

  logic      clk, rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;
  logic      cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  clip_scoreboard sb;
  int  idle_cycles;
  bit  hold_off_req;

  textured_rect_clip_uv_adjust_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // while set, the receiver never stalls
  bit quiet_phase;

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall)
        sb.check_result(out_data);
      if (in_valid && !in_stall)
        sb.note_input(in_data);
      if (idle_cycles > STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver side
  initial begin
    int g;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (60) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall = 1'b0;
      end else if (quiet_phase) begin
        out_stall = 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_stall = 1'b1;
          repeat (g) @(negedge clk);
        end
        out_stall = 1'b0;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_scissor(logic en, logic [15:0] l, logic [15:0] t,
                             logic [15:0] r, logic [15:0] b);
    write_reg(REG_CLIP_ENABLE, {15'd0, en});
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_BOTTOM, b);
  endtask

  // caller is at a negedge; returns at a negedge after the beat is taken
  task automatic send_rect(in_item_t it, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_pix(int lo, int hi);
    int v;
    v = $urandom_range(hi - lo) + lo;
    return v[15:0];
  endfunction

  function automatic in_item_t rand_rect(int mode);
    in_item_t it;
    it.tex_u_start = UV_W'($urandom); it.tex_v_start = UV_W'($urandom);
    it.tex_u_end   = UV_W'($urandom); it.tex_v_end   = UV_W'($urandom);
    if (mode == 0) begin
      it.rect_left = 16'($urandom); it.rect_top = 16'($urandom);
      it.rect_right = 16'($urandom); it.rect_bottom = 16'($urandom);
    end else begin
      // rectangles around the scissor so that edges clip
      it.rect_left   = rand_pix(-300, 200);
      it.rect_top    = rand_pix(-300, 200);
      it.rect_right  = rand_pix(-100, 400);
      it.rect_bottom = rand_pix(-100, 400);
    end
    return it;
  endfunction

  task automatic directed_set();
    in_item_t it;
    logic [15:0] edges[4];
    edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    for (int k = 0; k < 4; k++) begin
      it.rect_left = edges[k]; it.rect_top = edges[3-k];
      it.rect_right = edges[(k+1)%4]; it.rect_bottom = edges[(k+2)%4];
      it.tex_u_start = k[0] ? UV_MAX : '0; it.tex_v_start = k[1] ? '0 : UV_MAX;
      it.tex_u_end = k[0] ? '0 : UV_MAX;   it.tex_v_end = k[1] ? UV_MAX : '0;
      send_rect(it, 1'b0);
    end
    // wide rectangle over the whole coordinate range, large spans
    it = '{rect_left: -16'sd32768, rect_top: -16'sd32768, rect_right: 16'sd32767,
           rect_bottom: 16'sd32767, tex_u_start: '0, tex_v_start: UV_MAX,
           tex_u_end: UV_MAX, tex_v_end: '0};
    send_rect(it, 1'b0);
    // zero and negative extent
    it = '{rect_left: -16'sd50, rect_top: -16'sd50, rect_right: -16'sd50,
           rect_bottom: -16'sd60, tex_u_start: 17'd100, tex_v_start: 17'd200,
           tex_u_end: 17'd300, tex_v_end: 17'd400};
    send_rect(it, 1'b0);
    // fully inside, then fully outside
    it = '{rect_left: 16'sd10, rect_top: 16'sd10, rect_right: 16'sd20,
           rect_bottom: 16'sd20, tex_u_start: 17'd0, tex_v_start: 17'd0,
           tex_u_end: 17'd65536, tex_v_end: 17'd65536};
    send_rect(it, 1'b0);
    it.rect_left = 16'sd1000; it.rect_right = 16'sd2000;
    send_rect(it, 1'b0);
    // saturation both ways
    it = '{rect_left: -16'sd10, rect_top: -16'sd10, rect_right: 16'sd1,
           rect_bottom: 16'sd1, tex_u_start: UV_MAX, tex_v_start: 17'd5,
           tex_u_end: 17'd0, tex_v_end: UV_MAX};
    send_rect(it, 1'b0);
    for (int k = 0; k < 6; k++) send_rect(rand_rect(k % 2), 1'b1);
  endtask

  initial begin
    in_item_t it;
    sb = new();
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    hold_off_req = 1'b0; quiet_phase = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset scissor, clipping off
    directed_set();
    drain();
    set_scissor(1'b1, 16'd0, 16'd0, 16'd100, 16'd100);
    directed_set();
    drain();
    set_scissor(1'b1, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    directed_set();
    drain();
    set_scissor(1'b1, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    directed_set();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_scissor(1'b1, 16'd0, 16'd0, 16'd127, 16'd127);
        1: set_scissor(1'b1, 16'hffc0, 16'd20, 16'd64, 16'd300);
        2: set_scissor(1'b0, 16'd5, 16'd5, 16'd6, 16'd6);
        3: set_scissor(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
        4: set_scissor(1'b1, 16'd50, 16'hff00, 16'd50, 16'd0);
        default: set_scissor(1'b1, 16'h8000, 16'd0, 16'd200, 16'h7fff);
      endcase
      for (int n = 0; n < 230; n++) begin
        if (ph == 1 && n == 40) hold_off_req = 1'b1;
        if (ph == 2 && n == 100) begin
          while (sb.pending.size() != 0) @(negedge clk);
        end
        quiet_phase = (ph == 4 && n >= 100 && n < 160);
        send_rect(rand_rect($urandom_range(3) == 0 ? 0 : 1),
                  !(ph == 4 && n >= 100 && n < 160));
      end
      quiet_phase = 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/trcuv_pkg.sv
design/trcuv_front.sv
design/trcuv_div.sv
design/trcuv_back.sv
design/textured_rect_clip_uv_adjust_top.sv
tb/textured_rect_clip_uv_adjust_top_test.sv
